[src/id3_pkg.sv]
package id3_pkg;

  // Result codes
  localparam logic [1:0] KIND_CHAR  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;
  localparam logic [1:0] KIND_TRUNC = 2'd3;

  // Text selector codes
  localparam logic TEXT_ARTIST = 1'b0;
  localparam logic TEXT_TITLE  = 1'b1;

  // Configuration register indexes
  localparam logic CFG_ARTIST_CAP = 1'b0;
  localparam logic CFG_TITLE_CAP  = 1'b1;

  localparam int CAP_W = 9;
  localparam logic [CAP_W-1:0] CAP_RESET = 9'd64;

  localparam int OFFSET_W = 29;

  // Frame identifiers
  localparam logic [31:0] ID_ARTIST = 32'h5450_4531;  // TPE1
  localparam logic [31:0] ID_TITLE  = 32'h5449_5432;  // TIT2

  typedef struct packed {
    logic [1:0]          result_kind;
    logic                which_text;
    logic [7:0]          text_char;
    logic                text_last;
    logic [OFFSET_W-1:0] audio_offset;
    logic                last_in_run;
  } result_t;

  // 28-bit syncsafe integer from four bytes, seven bits each
  function automatic logic [27:0] syncsafe(input logic [7:0] b0, input logic [7:0] b1,
                                           input logic [7:0] b2, input logic [7:0] b3);
    syncsafe = {b0[6:0], b1[6:0], b2[6:0], b3[6:0]};
  endfunction

endpackage

[src/id3v2_tag_parser.sv]
// ID3v2 tag parser: walks the start of an audio file one byte at a time.
// Input channel (in_valid / in_stall): one file byte per request, with
// end_of_file marking the final byte; the parser restarts on the next byte.
// Output channel (out_valid / out_stall): one result per request: a text
// character of the artist or title, an empty-text marker, the tag end with
// the audio start offset, or a truncation error. last_in_run flags the
// final result caused by a byte (a byte causes zero, one or two).
// Config port (cfg_write / cfg_index / cfg_data): artist and title
// capacities; write them only while the parser is idle.
// Path: an accepted byte is captured in the input register, decoded from there,
// and its results are written to the result queue, whose head is presented.
// Throughput: one byte per cycle while the result queue has room; the single
// decode stage updates all the parser state from one registered byte. Two
// results of one byte leave one by one; a four-entry result queue absorbs that.
// Stalls: when the result queue cannot take two more results, the input
// register holds its byte and in_stall rises until the receiver drains.
// Reset: parser returns to the main header, capacities return to 64, and
// both channels come up empty.
module id3v2_tag_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    byte_value,
  input  logic                          end_of_file,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    result_kind,
  output logic                          which_text,
  output logic [7:0]                    text_char,
  output logic                          text_last,
  output logic [id3_pkg::OFFSET_W-1:0]  audio_offset,
  output logic                          last_in_run,
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [id3_pkg::CAP_W-1:0]     cfg_data
);

  logic [id3_pkg::CAP_W-1:0] artist_capacity, title_capacity;

  // Input register
  logic       ir_valid;
  logic [7:0] ir_byte;
  logic       ir_eof;

  logic             proc;
  logic             room;
  logic [1:0]       res_cnt;
  id3_pkg::result_t res0, res1, head;

  // Decode the held byte once the queue has space for both results
  assign proc     = ir_valid && room;
  assign in_stall = ir_valid && !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (!in_stall) begin
      ir_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      ir_byte <= byte_value;
      ir_eof  <= end_of_file;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      artist_capacity <= id3_pkg::CAP_RESET;
      title_capacity  <= id3_pkg::CAP_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        id3_pkg::CFG_ARTIST_CAP: artist_capacity <= cfg_data;
        id3_pkg::CFG_TITLE_CAP:  title_capacity  <= cfg_data;
        default: ;
      endcase
    end
  end

  id3_parse_core u_core (
    .clk        (clk),
    .rst        (rst),
    .take       (proc),
    .byte_in    (ir_byte),
    .eof_in     (ir_eof),
    .artist_cap (artist_capacity),
    .title_cap  (title_capacity),
    .res_cnt    (res_cnt),
    .res0       (res0),
    .res1       (res1)
  );

  id3_result_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (proc),
    .push_cnt   (res_cnt),
    .push0      (res0),
    .push1      (res1),
    .pop        (out_valid && !out_stall),
    .room       (room),
    .head_valid (out_valid),
    .head       (head)
  );

  assign result_kind  = head.result_kind;
  assign which_text   = head.which_text;
  assign text_char    = head.text_char;
  assign text_last    = head.text_last;
  assign audio_offset = head.audio_offset;
  assign last_in_run  = head.last_in_run;

endmodule

[src/id3_parse_core.sv]
module id3_parse_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,
  input  logic [7:0]                    byte_in,
  input  logic                          eof_in,
  input  logic [id3_pkg::CAP_W-1:0]     artist_cap,
  input  logic [id3_pkg::CAP_W-1:0]     title_cap,
  output logic [1:0]                    res_cnt,
  output id3_pkg::result_t              res0,
  output id3_pkg::result_t              res1
);

  typedef enum logic [3:0] {
    PH_MAIN, PH_EXT, PH_EXT_SKIP, PH_FRAME, PH_FRAME_SKIP,
    PH_TEXT_ENC, PH_TEXT_DATA, PH_TEXT_SKIP, PH_DONE
  } phase_t;

  phase_t      phase, phase_next;
  logic [3:0]  hdr_cnt, hdr_cnt_next;
  logic [7:0]  hbuf [10];
  logic [7:0]  hb [10];
  logic [27:0] tag_size, tag_size_next;
  logic [7:0]  tag_ver, tag_ver_next;
  logic [31:0] frame_size, frame_size_next;
  logic [31:0] skip_rem, skip_rem_next;
  logic [1:0]  frames_wanted, frames_wanted_next;
  logic        text_enc, text_enc_next;
  logic [8:0]  text_pos, text_pos_next;
  logic [8:0]  text_len, text_len_next;
  logic [7:0]  held, held_next;
  logic        text_sel, text_sel_next;

  logic        hdr_phase;
  logic        done_req;
  logic        a_v, t_v, e_v;
  id3_pkg::result_t a_res, t_res, e_res;
  logic [31:0] ext_sz, fsize, len32, fid;
  logic [8:0]  cap_eff;
  logic [27:0] end_off_unused;

  assign hdr_phase = (phase == PH_MAIN) || (phase == PH_EXT) || (phase == PH_FRAME);
  assign end_off_unused = tag_size;

  // Header bytes as seen with the current byte merged in
  always_comb begin
    for (int i = 0; i < 10; i++) begin
      hb[i] = (hdr_cnt == 4'(i)) ? byte_in : hbuf[i];
    end
  end

  always_comb begin
    phase_next         = phase;
    hdr_cnt_next       = hdr_cnt;
    tag_size_next      = tag_size;
    tag_ver_next       = tag_ver;
    frame_size_next    = frame_size;
    skip_rem_next      = skip_rem;
    frames_wanted_next = frames_wanted;
    text_enc_next      = text_enc;
    text_pos_next      = text_pos;
    text_len_next      = text_len;
    held_next          = held;
    text_sel_next      = text_sel;
    done_req = 1'b0;
    a_v = 1'b0;
    t_v = 1'b0;
    e_v = 1'b0;
    a_res = '0;
    t_res = '0;
    e_res = '0;
    ext_sz = '0;
    fsize = '0;
    len32 = '0;
    fid = '0;
    cap_eff = '0;

    unique case (phase)
      PH_MAIN: begin
        hdr_cnt_next = hdr_cnt + 4'd1;
        if (hdr_cnt == 4'd9) begin
          hdr_cnt_next = '0;
          if (hb[0] == 8'h49 && hb[1] == 8'h44 && hb[2] == 8'h33) begin
            tag_size_next = id3_pkg::syncsafe(hb[6], hb[7], hb[8], hb[9]);
            tag_ver_next  = hb[3];
            phase_next    = hb[5][6] ? PH_EXT : PH_FRAME;
          end else begin
            t_v = 1'b1;
            t_res.result_kind  = id3_pkg::KIND_END;
            t_res.audio_offset = '0;
            phase_next = PH_DONE;
          end
        end
      end
      PH_EXT: begin
        hdr_cnt_next = hdr_cnt + 4'd1;
        if (hdr_cnt == 4'd3) begin
          hdr_cnt_next  = '0;
          ext_sz        = {4'b0, id3_pkg::syncsafe(hb[0], hb[1], hb[2], hb[3])} - 32'd4;
          skip_rem_next = ext_sz;
          phase_next    = (ext_sz == '0) ? PH_FRAME : PH_EXT_SKIP;
        end
      end
      PH_EXT_SKIP, PH_FRAME_SKIP: begin
        skip_rem_next = skip_rem - 32'd1;
        if (skip_rem_next == '0) phase_next = PH_FRAME;
      end
      PH_FRAME: begin
        hdr_cnt_next = hdr_cnt + 4'd1;
        if (hdr_cnt == 4'd9) begin
          hdr_cnt_next = '0;
          if (hb[0] == 8'h00 || (hb[0] == 8'h33 && hb[1] == 8'h44 && hb[2] == 8'h49)) begin
            t_v = 1'b1;
            t_res.result_kind  = id3_pkg::KIND_END;
            t_res.audio_offset = {1'b0, tag_size} + 29'd10;
            phase_next = PH_DONE;
          end else begin
            fid = {hb[0], hb[1], hb[2], hb[3]};
            if (tag_ver == 8'd3) begin
              fsize = {hb[4], hb[5], hb[6], hb[7]};
            end else if (tag_ver == 8'd4) begin
              fsize = {4'b0, id3_pkg::syncsafe(hb[4], hb[5], hb[6], hb[7])};
            end
            frame_size_next = fsize;
            if (fid == id3_pkg::ID_ARTIST || fid == id3_pkg::ID_TITLE) begin
              text_sel_next = (fid == id3_pkg::ID_TITLE) ? id3_pkg::TEXT_TITLE
                                                         : id3_pkg::TEXT_ARTIST;
              phase_next = PH_TEXT_ENC;
            end else if (fsize == '0) begin
              phase_next = PH_FRAME;
            end else begin
              skip_rem_next = fsize;
              phase_next    = PH_FRAME_SKIP;
            end
          end
        end
      end
      PH_TEXT_ENC: begin
        cap_eff = text_sel ? title_cap : artist_cap;
        if (cap_eff == '0) cap_eff = 9'd1;
        len32           = frame_size - 32'd1;
        frame_size_next = len32;
        text_len_next   = len32[8:0];
        text_pos_next   = '0;
        if (len32 < {23'b0, cap_eff} && len32 != '0 && byte_in[7:1] == 7'd0) begin
          text_enc_next = byte_in[0];
          phase_next    = PH_TEXT_DATA;
        end else begin
          a_v = 1'b1;
          a_res.result_kind = id3_pkg::KIND_EMPTY;
          a_res.which_text  = text_sel;
          if (len32 == '0) begin
            done_req = 1'b1;
          end else begin
            skip_rem_next = len32;
            phase_next    = PH_TEXT_SKIP;
          end
        end
      end
      PH_TEXT_DATA: begin
        a_res.result_kind = id3_pkg::KIND_CHAR;
        a_res.which_text  = text_sel;
        if (!text_enc) begin
          a_v = 1'b1;
          a_res.text_char = byte_in;
          a_res.text_last = ({1'b0, text_pos} + 10'd1) == {1'b0, text_len};
        end else if (text_len > 9'd2 && text_pos == 9'd0) begin
          held_next = byte_in;
        end else if (text_len > 9'd2 && text_pos == 9'd1) begin
          // drop a little-endian byte-order mark
          if (!(held == 8'hFF && byte_in == 8'hFE)) begin
            a_v = 1'b1;
            a_res.text_char = held;
          end
        end else if (!text_pos[0]) begin
          a_v = 1'b1;
          a_res.text_char = byte_in;
          a_res.text_last = ({1'b0, text_pos} + 10'd2) >= {1'b0, text_len};
        end
        text_pos_next = text_pos + 9'd1;
        if (text_pos_next >= text_len) done_req = 1'b1;
      end
      PH_TEXT_SKIP: begin
        skip_rem_next = skip_rem - 32'd1;
        if (skip_rem_next == '0) done_req = 1'b1;
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase

    if (done_req) begin
      frames_wanted_next = (frames_wanted != 2'd0) ? frames_wanted - 2'd1 : 2'd0;
      if (frames_wanted_next == 2'd0) begin
        t_v = 1'b1;
        t_res.result_kind  = id3_pkg::KIND_END;
        t_res.audio_offset = {1'b0, end_off_unused} + 29'd10;
        phase_next = PH_DONE;
      end else begin
        phase_next = PH_FRAME;
      end
    end

    if (eof_in) begin
      e_v = (phase_next != PH_DONE);
      e_res.result_kind = id3_pkg::KIND_TRUNC;
      phase_next         = PH_MAIN;
      hdr_cnt_next       = '0;
      frames_wanted_next = 2'd2;
      text_sel_next      = id3_pkg::TEXT_ARTIST;
    end
  end

  // Pack up to two results in order and mark the last one
  always_comb begin
    res_cnt = 2'(a_v) + 2'(t_v) + 2'(e_v);
    res0 = a_v ? a_res : (t_v ? t_res : e_res);
    res1 = a_v ? (t_v ? t_res : e_res) : e_res;
    res0.last_in_run = (res_cnt == 2'd1);
    res1.last_in_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_MAIN;
      hdr_cnt       <= '0;
      frames_wanted <= 2'd2;
      text_sel      <= id3_pkg::TEXT_ARTIST;
    end else if (take) begin
      phase         <= phase_next;
      hdr_cnt       <= hdr_cnt_next;
      frames_wanted <= frames_wanted_next;
      text_sel      <= text_sel_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (hdr_phase) hbuf[hdr_cnt] <= byte_in;
      tag_size   <= tag_size_next;
      tag_ver    <= tag_ver_next;
      frame_size <= frame_size_next;
      skip_rem   <= skip_rem_next;
      text_enc   <= text_enc_next;
      text_pos   <= text_pos_next;
      text_len   <= text_len_next;
      held       <= held_next;
    end
  end

endmodule

[src/id3_result_fifo.sv]
module id3_result_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [1:0]       push_cnt,
  input  id3_pkg::result_t push0,
  input  id3_pkg::result_t push1,
  input  logic             pop,
  output logic             room,
  output logic             head_valid,
  output id3_pkg::result_t head
);

  id3_pkg::result_t mem [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;
  logic [1:0] n_in;

  assign n_in       = push ? push_cnt : 2'd0;
  assign room       = (count <= 3'd2);
  assign head_valid = (count != 3'd0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_in;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + 3'(n_in) - 3'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (n_in != 2'd0) mem[wr_ptr] <= push0;
    if (n_in == 2'd2) mem[wr_ptr + 2'd1] <= push1;
  end

endmodule

[bench/tb_id3v2_tag_parser.sv]
module tb_id3v2_tag_parser;

  // Byte codes the parser keys on
  localparam logic [23:0] ID3_MAGIC    = 24'h49_44_33;  // "ID3"
  localparam logic [23:0] FOOTER_MAGIC = 24'h33_44_49;  // "3DI"
  localparam logic [7:0]  BOM_FIRST    = 8'hFF;
  localparam logic [7:0]  BOM_SECOND   = 8'hFE;
  localparam logic [7:0]  PAD_BYTE     = 8'h00;
  localparam logic [7:0]  ENC_LATIN1   = 8'd0;
  localparam logic [7:0]  ENC_UTF16    = 8'd1;
  localparam logic [7:0]  ENC_OTHER    = 8'd2;
  localparam logic [7:0]  VER_PLAIN    = 8'd3;   // plain 32-bit frame sizes
  localparam logic [7:0]  VER_SYNCSAFE = 8'd4;   // syncsafe frame sizes
  localparam logic [7:0]  VER_OLD      = 8'd2;   // frame sizes read as zero
  localparam int          EXT_FLAG_BIT = 6;
  localparam logic [7:0]  EXT_FLAG     = 8'h40;

  localparam int MAX_RUN        = 2;     // results one byte can cause
  localparam int PHASE_BYTES    = 20;    // least number of bytes queued per capacity setting
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef enum logic [3:0] {
    PH_HEADER, PH_EXT_SIZE, PH_EXT_SKIP, PH_FRAME_HDR, PH_FRAME_SKIP,
    PH_TEXT_ENC, PH_TEXT_BODY, PH_TEXT_SKIP, PH_TAG_DONE
  } parse_phase_t;

  typedef logic [id3_pkg::CAP_W-1:0] cap_t;

  typedef struct packed {
    logic [7:0] value;
    logic       eof;
  } stream_byte_t;

  // ---------------------------------------------------------------------
  // Block ports
  // ---------------------------------------------------------------------
  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [7:0]                   byte_value = '0;
  logic                         end_of_file = 1'b0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [1:0]                   result_kind;
  logic                         which_text;
  logic [7:0]                   text_char;
  logic                         text_last;
  logic [id3_pkg::OFFSET_W-1:0] audio_offset;
  logic                         last_in_run;
  logic                         cfg_write = 1'b0;
  logic                         cfg_index = id3_pkg::CFG_ARTIST_CAP;
  logic [id3_pkg::CAP_W-1:0]    cfg_data = '0;

  id3v2_tag_parser i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .byte_value   (byte_value),
    .end_of_file  (end_of_file),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_kind  (result_kind),
    .which_text   (which_text),
    .text_char    (text_char),
    .text_last    (text_last),
    .audio_offset (audio_offset),
    .last_in_run  (last_in_run),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // Parser shadow: own copy of the capacities and of every state field
  // ---------------------------------------------------------------------
  logic [id3_pkg::CAP_W-1:0] artist_cap;
  logic [id3_pkg::CAP_W-1:0] title_cap;

  parse_phase_t phase;
  logic [31:0]  hdr_cnt;
  logic [27:0]  tag_size;
  logic [7:0]   tag_ver;
  logic [31:0]  frame_id;
  logic [31:0]  frame_size;
  logic [31:0]  skip_left;
  logic [1:0]   frames_wanted;
  logic [7:0]   text_enc;
  logic [31:0]  text_pos;
  logic [7:0]   hbuf [10];
  logic [7:0]   held_char;
  logic         text_sel;

  id3_pkg::result_t byte_results[$];       // results of the byte being parsed
  id3_pkg::result_t expected_results[$];   // results owed by the block, oldest first

  stream_byte_t pending_bytes[$]; // bytes waiting for the driver
  logic [7:0]   file_bytes[$];    // stream under construction

  int bytes_queued = 0;
  int bytes_taken  = 0;
  int streams      = 0;
  int settings     = 1;
  int results_seen = 0;
  int errors       = 0;
  int kind_count [4] = '{0, 0, 0, 0};

  function automatic void reset_parser();
    phase         = PH_HEADER;
    hdr_cnt       = '0;
    tag_size      = '0;
    tag_ver       = '0;
    frame_id      = '0;
    frame_size    = '0;
    skip_left     = '0;
    frames_wanted = 2'd2;
    text_enc      = '0;
    text_pos      = '0;
    foreach (hbuf[i]) hbuf[i] = '0;
    held_char     = '0;
    text_sel      = id3_pkg::TEXT_ARTIST;
  endfunction

  // Seven low bits of four header bytes, most significant first
  function automatic logic [27:0] unsync(input int base);
    logic [27:0] v;
    v = '0;
    for (int i = 0; i < 4; i++) v = {v[20:0], hbuf[base + i][6:0]};
    return v;
  endfunction

  function automatic void store_hdr_byte(input logic [7:0] b);
    if (hdr_cnt < 10) hbuf[hdr_cnt] = b;
    hdr_cnt++;
  endfunction

  // Drop anything past the second result of a byte
  function automatic void add_result(input logic [1:0] kind, input logic which,
                                     input logic [7:0] ch, input logic last,
                                     input logic [id3_pkg::OFFSET_W-1:0] off);
    id3_pkg::result_t r;
    if (byte_results.size() >= MAX_RUN) return;
    r.result_kind  = kind;
    r.which_text   = which;
    r.text_char    = ch;
    r.text_last    = last;
    r.audio_offset = off;
    r.last_in_run  = 1'b0;
    byte_results.push_back(r);
  endfunction

  function automatic void finish_tag(input logic [id3_pkg::OFFSET_W-1:0] off);
    add_result(id3_pkg::KIND_END, id3_pkg::TEXT_ARTIST, '0, 1'b0, off);
    phase = PH_TAG_DONE;
  endfunction

  // One wanted frame is through; stop once both have been seen
  function automatic void close_text();
    if (frames_wanted > 0) frames_wanted--;
    if (frames_wanted == 0) finish_tag({1'b0, tag_size} + 29'd10);
    else phase = PH_FRAME_HDR;
  endfunction

  function automatic void parse_file_byte(input logic [7:0] b, input logic eof);
    logic [31:0]               pos;
    logic [31:0]               len;
    logic [id3_pkg::CAP_W-1:0] cap;
    byte_results.delete();
    case (phase)
      PH_HEADER: begin
        store_hdr_byte(b);
        if (hdr_cnt >= 10) begin
          hdr_cnt = '0;
          if ({hbuf[0], hbuf[1], hbuf[2]} == ID3_MAGIC) begin
            tag_size = unsync(6);
            tag_ver  = hbuf[3];
            phase    = hbuf[5][EXT_FLAG_BIT] ? PH_EXT_SIZE : PH_FRAME_HDR;
          end else begin
            finish_tag('0);
          end
        end
      end
      PH_EXT_SIZE: begin
        store_hdr_byte(b);
        if (hdr_cnt >= 4) begin
          hdr_cnt   = '0;
          skip_left = {4'b0, unsync(0)} - 32'd4;
          phase     = (skip_left == 0) ? PH_FRAME_HDR : PH_EXT_SKIP;
        end
      end
      PH_EXT_SKIP, PH_FRAME_SKIP: begin
        skip_left--;
        if (skip_left == 0) phase = PH_FRAME_HDR;
      end
      PH_FRAME_HDR: begin
        store_hdr_byte(b);
        if (hdr_cnt >= 10) begin
          hdr_cnt = '0;
          if (hbuf[0] == PAD_BYTE || {hbuf[0], hbuf[1], hbuf[2]} == FOOTER_MAGIC) begin
            finish_tag({1'b0, tag_size} + 29'd10);
          end else begin
            frame_id = {hbuf[0], hbuf[1], hbuf[2], hbuf[3]};
            if (tag_ver == VER_PLAIN) frame_size = {hbuf[4], hbuf[5], hbuf[6], hbuf[7]};
            else if (tag_ver == VER_SYNCSAFE) frame_size = {4'b0, unsync(4)};
            else frame_size = '0;
            if (frame_id == id3_pkg::ID_ARTIST || frame_id == id3_pkg::ID_TITLE) begin
              text_sel = (frame_id == id3_pkg::ID_TITLE) ? id3_pkg::TEXT_TITLE
                                                         : id3_pkg::TEXT_ARTIST;
              phase    = PH_TEXT_ENC;
            end else if (frame_size == 0) begin
              phase = PH_FRAME_HDR;
            end else begin
              skip_left = frame_size;
              phase     = PH_FRAME_SKIP;
            end
          end
        end
      end
      PH_TEXT_ENC: begin
        cap = (text_sel == id3_pkg::TEXT_TITLE) ? title_cap : artist_cap;
        if (cap == 0) cap = cap_t'(1);
        len        = frame_size - 32'd1;   // wraps for a zero frame size
        text_enc   = b;
        frame_size = len;
        text_pos   = '0;
        if (len < {23'b0, cap} && len != 0 && (b == ENC_LATIN1 || b == ENC_UTF16)) begin
          phase = PH_TEXT_BODY;
        end else begin
          add_result(id3_pkg::KIND_EMPTY, text_sel, '0, 1'b0, '0);
          if (len == 0) begin
            close_text();
          end else begin
            skip_left = len;
            phase     = PH_TEXT_SKIP;
          end
        end
      end
      PH_TEXT_BODY: begin
        pos = text_pos;
        len = frame_size;
        if (text_enc == ENC_LATIN1) begin
          add_result(id3_pkg::KIND_CHAR, text_sel, b, pos + 1 == len, '0);
        end else if (len > 2 && pos == 0) begin
          held_char = b;
        end else if (len > 2 && pos == 1) begin
          // Hold back the first byte one step; drop it with the FF FE mark
          if (!(held_char == BOM_FIRST && b == BOM_SECOND))
            add_result(id3_pkg::KIND_CHAR, text_sel, held_char, 1'b0, '0);
        end else if (!pos[0]) begin
          add_result(id3_pkg::KIND_CHAR, text_sel, b,
                     {1'b0, pos} + 33'd2 >= {1'b0, len}, '0);
        end
        text_pos = pos + 1;
        if (text_pos >= len) close_text();
      end
      PH_TEXT_SKIP: begin
        skip_left--;
        if (skip_left == 0) close_text();
      end
      default: ;
    endcase
    if (eof) begin
      if (phase != PH_TAG_DONE)
        add_result(id3_pkg::KIND_TRUNC, id3_pkg::TEXT_ARTIST, '0, 1'b0, '0);
      reset_parser();
    end
    if (byte_results.size() > 0) byte_results[byte_results.size() - 1].last_in_run = 1'b1;
    foreach (byte_results[i]) expected_results.push_back(byte_results[i]);
  endfunction

  // ---------------------------------------------------------------------
  // Stream building
  // ---------------------------------------------------------------------
  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Seven size bits per byte; the top bit is noise the parser must mask
  task automatic put_sync(input logic [27:0] v);
    for (int i = 3; i >= 0; i--)
      file_bytes.push_back({1'($urandom_range(0, 1)), v[7*i +: 7]});
  endtask

  task automatic put_tag_hdr(input logic [7:0] ver, input logic [7:0] flags,
                             input logic [27:0] size);
    file_bytes.push_back(ID3_MAGIC[23:16]);
    file_bytes.push_back(ID3_MAGIC[15:8]);
    file_bytes.push_back(ID3_MAGIC[7:0]);
    file_bytes.push_back(ver);
    file_bytes.push_back(rand_byte());
    file_bytes.push_back(flags);
    put_sync(size);
  endtask

  task automatic put_frame_hdr(input logic [31:0] id, input logic [7:0] ver,
                               input logic [31:0] size);
    for (int i = 3; i >= 0; i--) file_bytes.push_back(id[8*i +: 8]);
    if (ver == VER_PLAIN)
      for (int i = 3; i >= 0; i--) file_bytes.push_back(size[8*i +: 8]);
    else if (ver == VER_SYNCSAFE)
      put_sync(size[27:0]);
    else
      repeat (4) file_bytes.push_back(rand_byte());
    repeat (2) file_bytes.push_back(rand_byte());
  endtask

  task automatic put_bytes(input int n);
    repeat (n) file_bytes.push_back(rand_byte());
  endtask

  // Hand the stream to the driver, optionally cut short; mark its last byte
  task automatic send_stream(input bit may_cut);
    int           n;
    stream_byte_t sb;
    n = file_bytes.size();
    if (may_cut && n > 1 && $urandom_range(0, 6) == 0) n = $urandom_range(1, n - 1);
    for (int i = 0; i < n; i++) begin
      sb.value = file_bytes[i];
      sb.eof   = (i == n - 1);
      pending_bytes.push_back(sb);
      bytes_queued++;
    end
    file_bytes.delete();
    streams++;
  endtask

  // A tag with random layout: mostly artist and title frames, some others,
  // then padding, a footer or nothing, and a little audio
  task automatic gen_tagged_file();
    logic [7:0]  ver;
    logic [7:0]  flags;
    logic [7:0]  enc;
    logic [31:0] id;
    int          ext_size;
    int          cap;
    int          len;
    int          r;
    r = $urandom_range(0, 9);
    ver = (r < 4) ? VER_PLAIN : (r < 8) ? VER_SYNCSAFE : rand_byte();
    flags = rand_byte();
    flags[EXT_FLAG_BIT] = ($urandom_range(0, 3) == 0);
    put_tag_hdr(ver, flags,
                ($urandom_range(0, 3) == 0) ? 28'($urandom) : 28'($urandom_range(0, 4000)));
    if (flags[EXT_FLAG_BIT]) begin
      ext_size = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 10);
      put_sync(28'(ext_size));
      if (ext_size >= 4) put_bytes(ext_size - 4);
    end
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 9) < 7) begin
        id  = $urandom_range(0, 1) ? id3_pkg::ID_TITLE : id3_pkg::ID_ARTIST;
        cap = (id == id3_pkg::ID_TITLE) ? title_cap : artist_cap;
        if (cap == 0) cap = 1;
        r   = $urandom_range(0, 9);
        enc = (r < 4) ? ENC_LATIN1 : (r < 8) ? ENC_UTF16 : rand_byte();
        case ($urandom_range(0, 9))
          0:       len = $urandom_range(0, 2);
          1:       len = cap - 2 + $urandom_range(0, 2);   // straddle the capacity
          default: len = $urandom_range(1, 10);
        endcase
        if (len < 0) len = 0;
        put_frame_hdr(id, ver, len + 1);
        file_bytes.push_back(enc);
        if (enc == ENC_UTF16 && len > 2 && $urandom_range(0, 1)) begin
          file_bytes.push_back(BOM_FIRST);
          file_bytes.push_back(BOM_SECOND);
          put_bytes(len - 2);
        end else begin
          put_bytes(len);
        end
      end else begin
        for (int i = 0; i < 4; i++) id[8*i +: 8] = 8'h41 + 8'($urandom_range(0, 25));
        len = $urandom_range(0, 8);
        put_frame_hdr(id, ver, len);
        if (ver == VER_PLAIN || ver == VER_SYNCSAFE) put_bytes(len);
      end
    end
    case ($urandom_range(0, 3))
      0: repeat (10) file_bytes.push_back(PAD_BYTE);
      1: begin
        file_bytes.push_back(FOOTER_MAGIC[23:16]);
        file_bytes.push_back(FOOTER_MAGIC[15:8]);
        file_bytes.push_back(FOOTER_MAGIC[7:0]);
        put_bytes(7);
      end
      default: ;
    endcase
    put_bytes($urandom_range(0, 4));
    send_stream(1'b1);
  endtask

  // Junk, sometimes behind a valid magic
  task automatic gen_noise();
    if ($urandom_range(0, 1)) begin
      file_bytes.push_back(ID3_MAGIC[23:16]);
      file_bytes.push_back(ID3_MAGIC[15:8]);
      file_bytes.push_back(ID3_MAGIC[7:0]);
    end
    put_bytes($urandom_range(1, 24));
    send_stream(1'b0);
  endtask

  // Write both capacities while the parser is idle
  task automatic set_caps(input logic [id3_pkg::CAP_W-1:0] a,
                          input logic [id3_pkg::CAP_W-1:0] t);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= id3_pkg::CFG_ARTIST_CAP;
    cfg_data  <= a;
    @(posedge clk);
    cfg_index <= id3_pkg::CFG_TITLE_CAP;
    cfg_data  <= t;
    @(posedge clk);
    cfg_write <= 1'b0;
    artist_cap = a;
    title_cap  = t;
    settings++;
  endtask

  // Hold until every queued byte is taken and every result is back, then
  // give the decode stage time to finish bytes that cause no result
  task automatic wait_idle(input int settle);
    do @(posedge clk);
    while (bytes_taken != bytes_queued || expected_results.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic run_phase(input logic [id3_pkg::CAP_W-1:0] a,
                           input logic [id3_pkg::CAP_W-1:0] t);
    int start;
    set_caps(a, t);
    start = bytes_queued;
    while (bytes_queued - start < PHASE_BYTES) begin
      if ($urandom_range(0, 4) == 0) gen_noise();
      else gen_tagged_file();
    end
    wait_idle(SETTLE_CYCLES);
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  initial begin
    reset_parser();
    artist_cap = id3_pkg::CAP_RESET;
    title_cap  = id3_pkg::CAP_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // End of file on the very first byte: truncated at once
    file_bytes.push_back(8'hFF);
    send_stream(1'b0);

    // Wrong magic: tag end with offset zero, the rest ignored
    file_bytes.push_back(ID3_MAGIC[23:16]);
    file_bytes.push_back(ID3_MAGIC[15:8]);
    file_bytes.push_back(8'h34);
    put_bytes(9);
    send_stream(1'b0);

    // Largest tag size, extended header, UTF-16 artist behind a byte-order mark whose
    // spare zero byte starts the next frame header: padding ends the tag before the one-char title
    put_tag_hdr(VER_SYNCSAFE, EXT_FLAG, 28'hFFF_FFFF);
    put_sync(28'd6);
    put_bytes(2);
    put_frame_hdr(id3_pkg::ID_ARTIST, VER_SYNCSAFE, 32'd6);
    file_bytes.push_back(ENC_UTF16);
    file_bytes.push_back(BOM_FIRST);
    file_bytes.push_back(BOM_SECOND);
    file_bytes.push_back(8'h41);
    file_bytes.push_back(8'h00);
    file_bytes.push_back(8'h42);
    file_bytes.push_back(8'h00);
    put_frame_hdr(id3_pkg::ID_TITLE, VER_PLAIN, 32'd2);
    file_bytes.push_back(ENC_LATIN1);
    file_bytes.push_back(8'h5A);
    put_bytes(1);
    send_stream(1'b0);

    // Extended header smaller than its own size field: skip wraps around
    put_tag_hdr(VER_PLAIN, EXT_FLAG, 28'd100);
    put_sync(28'd2);
    put_bytes(3);
    send_stream(1'b0);

    // Zero frame size on a title: empty text, then a wrapped skip
    put_tag_hdr(VER_PLAIN, 8'h00, 28'd50);
    put_frame_hdr(id3_pkg::ID_TITLE, VER_PLAIN, 32'd0);
    file_bytes.push_back(ENC_LATIN1);
    put_bytes(2);
    send_stream(1'b0);

    // Old version: other frame reads as size zero; padding ends the tag
    put_tag_hdr(VER_OLD, 8'h00, 28'd7);
    put_frame_hdr(32'h4142_4344, VER_OLD, 32'd0);
    repeat (10) file_bytes.push_back(PAD_BYTE);
    put_bytes(1);
    send_stream(1'b0);

    // Zero-length artist, then a title with an unknown encoding
    put_tag_hdr(VER_PLAIN, 8'h00, 28'd20);
    put_frame_hdr(id3_pkg::ID_ARTIST, VER_PLAIN, 32'd1);
    file_bytes.push_back(ENC_LATIN1);
    put_frame_hdr(id3_pkg::ID_TITLE, VER_PLAIN, 32'd4);
    file_bytes.push_back(ENC_OTHER);
    put_bytes(3);
    send_stream(1'b0);

    // Skipped frame, then a footer
    put_tag_hdr(VER_SYNCSAFE, 8'h00, 28'd30);
    put_frame_hdr(32'h5458_5858, VER_SYNCSAFE, 32'd3);
    put_bytes(3);
    file_bytes.push_back(FOOTER_MAGIC[23:16]);
    file_bytes.push_back(FOOTER_MAGIC[15:8]);
    file_bytes.push_back(FOOTER_MAGIC[7:0]);
    put_bytes(7);
    send_stream(1'b0);

    // UTF-16 without a full mark: the held FF comes out late; then a
    // two-byte UTF-16 title
    put_tag_hdr(VER_PLAIN, 8'h00, 28'd40);
    put_frame_hdr(id3_pkg::ID_ARTIST, VER_PLAIN, 32'd5);
    file_bytes.push_back(ENC_UTF16);
    file_bytes.push_back(BOM_FIRST);
    file_bytes.push_back(8'h41);
    file_bytes.push_back(8'h79);
    file_bytes.push_back(8'h00);
    put_frame_hdr(id3_pkg::ID_TITLE, VER_PLAIN, 32'd3);
    file_bytes.push_back(ENC_UTF16);
    file_bytes.push_back(8'h63);
    file_bytes.push_back(8'h00);
    send_stream(1'b0);

    // End of file on a text byte: the char and then the truncation
    put_tag_hdr(VER_PLAIN, 8'h00, 28'd40);
    put_frame_hdr(id3_pkg::ID_ARTIST, VER_PLAIN, 32'd4);
    file_bytes.push_back(ENC_LATIN1);
    file_bytes.push_back(8'h61);
    file_bytes.push_back(8'h62);
    send_stream(1'b0);

    // Pause the sender here until all results are back
    wait_idle(SETTLE_CYCLES);

    run_phase(9'd1, 9'd1);
    run_phase(9'd256, 9'd256);
    run_phase(9'd0, 9'd511);
    run_phase(9'd3, 9'd8);
    run_phase(cap_t'($urandom_range(1, 24)), cap_t'($urandom_range(1, 24)));

    wait_idle(20);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      errors++;
    end
    $display("Run: %0d bytes in %0d streams over %0d capacity settings, %0d results checked",
             bytes_taken, streams, settings, results_seen);
    $display("Run: %0d text chars, %0d empty texts, %0d tag ends, %0d truncations",
             kind_count[id3_pkg::KIND_CHAR], kind_count[id3_pkg::KIND_EMPTY],
             kind_count[id3_pkg::KIND_END], kind_count[id3_pkg::KIND_TRUNC]);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // Driver: bursts of requests with random gaps; a stalled request holds
  // ---------------------------------------------------------------------
  int           burst_left = 1;
  int           gap_left   = 0;
  stream_byte_t next_byte;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        parse_file_byte(byte_value, end_of_file);
        bytes_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          next_byte = pending_bytes.pop_front();
          byte_value  <= next_byte.value;
          end_of_file <= next_byte.eof;
          in_valid    <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            // Advance to a new burst; a zero gap gives long unbroken runs
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: compare each result with the oldest expectation; the stall
  // pattern switches among none, light, heavy and periodic
  // ---------------------------------------------------------------------
  int          stall_mode = 0;
  int          mode_left  = 0;
  logic [31:0] cycle_cnt  = '0;

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        kind_count[result_kind]++;
        if (expected_results.size() == 0) begin
          $error("unexpected result: kind %0d with nothing expected", result_kind);
          errors++;
        end else begin
          check_field("result_kind", expected_results[0].result_kind, result_kind);
          check_field("which_text", expected_results[0].which_text, which_text);
          check_field("text_char", expected_results[0].text_char, text_char);
          check_field("text_last", expected_results[0].text_last, text_last);
          check_field("audio_offset", expected_results[0].audio_offset, audio_offset);
          check_field("last_in_run", expected_results[0].last_in_run, last_in_run);
          void'(expected_results.pop_front());
        end
      end
      cycle_cnt <= cycle_cnt + 1;
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= (cycle_cnt[3:0] < 4'd5);
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Watchdog: end the run when no request moves for too long
  // ---------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
